### sv/fibonacci_term_mod_decimal_assert.svh
// Assertion macros for the Fibonacci term block.
// Each macro expects clk and arst_n to be visible at the place of use.
`ifndef FIBONACCI_TERM_MOD_DECIMAL_ASSERT_SVH
`define FIBONACCI_TERM_MOD_DECIMAL_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define FTMD_ASSERT_HOLDS(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ftmd: same-cycle check failed");

// Next-cycle implication.
`define FTMD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ftmd: next-cycle check failed");

`endif

### sv/ftmd_pkg.sv
// Shared types, constants and modular helpers for the Fibonacci term block.
// No dependencies; imported by every module of the block.
package ftmd_pkg;

	localparam int MAX_DIGITS = 4;
	localparam int DIG_W      = 3;   // digit count field
	localparam int IN_W       = 31;  // start terms and index
	localparam int VAL_W      = 14;  // residues, below 10^4
	localparam int OPD_W      = VAL_W + 1; // residue sums, below 2*10^4
	localparam int RCP_W      = 32;  // Barrett reciprocal, 2^31 / modulus
	localparam int PIPE_DEPTH = 4;   // mulmod pipeline depth in stages
	localparam int DRAIN_W    = 2;   // width of the controller's drain counter

	// Modulus 10^d and its reciprocal floor(2^31 / 10^d), by clamped digit count.
	localparam logic [VAL_W-1:0] MOD_TABLE [0:MAX_DIGITS] = '{
		14'd1, 14'd10, 14'd100, 14'd1000, 14'd10000
	};
	localparam logic [RCP_W-1:0] RECIP_TABLE [0:MAX_DIGITS] = '{
		32'd2147483648, 32'd214748364, 32'd21474836, 32'd2147483, 32'd214748
	};

	typedef enum logic [3:0] {
		OP_RED_A,
		OP_RED_B,
		OP_BASE_XX,
		OP_BASE_YY,
		OP_BASE_SS,
		OP_ACC_XX,
		OP_ACC_YY,
		OP_ACC_SS,
		OP_FIN_1,
		OP_FIN_2
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED,
		ST_RED_WAIT,
		ST_LOOP,
		ST_SQ_ISSUE,
		ST_SQ_WAIT,
		ST_UPDATE,
		ST_FIN_ISSUE,
		ST_FIN_WAIT,
		ST_FINISH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic issue;
		op_t  op;
		logic update;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic e_zero;
		logic e_lsb;
	} dp_stat_t;

	function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] p,
		input logic [VAL_W-1:0] q, input logic [VAL_W-1:0] md);
		logic [VAL_W:0] s;
		s = {1'b0, p} + {1'b0, q};
		if (s >= {1'b0, md}) begin
			s = s - {1'b0, md};
		end
		return s[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] mod_sub(input logic [VAL_W-1:0] p,
		input logic [VAL_W-1:0] q, input logic [VAL_W-1:0] md);
		logic [VAL_W:0] s;
		if (p >= q) begin
			s = {1'b0, p} - {1'b0, q};
		end else begin
			s = {1'b0, p} + {1'b0, md} - {1'b0, q};
		end
		return s[VAL_W-1:0];
	endfunction

endpackage

### sv/ftmd_mulmod.sv
// Four-stage modular multiply/reduce unit: product, Barrett quotient,
// quotient times modulus, subtract and correct. Depends on ftmd_pkg.
module ftmd_mulmod import ftmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  op_t              in_op,
	input  logic             raw_sel,
	input  logic [IN_W-1:0]  raw_val,
	input  logic [OPD_W-1:0] opa,
	input  logic [OPD_W-1:0] opb,
	input  logic [VAL_W-1:0] md,
	input  logic [RCP_W-1:0] recip,
	output logic             out_valid,
	output op_t              out_op,
	output logic [VAL_W-1:0] out_res
);

	logic [2*OPD_W-1:0]     prod;
	logic [IN_W+RCP_W-1:0]  qfull;
	logic [IN_W+VAL_W-1:0]  qm_full;
	logic [IN_W-1:0]        diff;
	logic [VAL_W:0]         rem;
	logic [VAL_W:0]         rem_fix;

	logic             valid_s1, valid_s2, valid_s3, valid_s4;
	op_t              op_s1, op_s2, op_s3, op_s4;
	logic [IN_W-1:0]  v_s1, v_s2, v_s3;
	logic [IN_W-1:0]  q_s2;
	logic [IN_W-1:0]  qm_s3;
	logic [VAL_W-1:0] res_s4;

	assign prod    = {{OPD_W{1'b0}}, opa} * {{OPD_W{1'b0}}, opb};
	assign qfull   = {{RCP_W{1'b0}}, v_s1} * {{IN_W{1'b0}}, recip};
	assign qm_full = {{VAL_W{1'b0}}, q_s2} * {{IN_W{1'b0}}, md};
	// remainder lands below twice the modulus; one correction
	assign diff    = v_s3 - qm_s3;
	assign rem     = diff[VAL_W:0];
	assign rem_fix = (rem >= {1'b0, md}) ? (rem - {1'b0, md}) : rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= in_op;
		v_s1   <= raw_sel ? raw_val : IN_W'(prod);
		op_s2  <= op_s1;
		v_s2   <= v_s1;
		q_s2   <= qfull[RCP_W-1 +: IN_W];
		op_s3  <= op_s2;
		v_s3   <= v_s2;
		qm_s3  <= qm_full[IN_W-1:0];
		op_s4  <= op_s3;
		res_s4 <= rem_fix[VAL_W-1:0];
	end

	assign out_valid = valid_s4;
	assign out_op    = op_s4;
	assign out_res   = res_s4;

endmodule

### sv/ftmd_datapath.sv
// Datapath: operand registers, matrix power state and the mulmod unit.
// Depends on ftmd_pkg, ftmd_mulmod and the assertion macro header.
`include "fibonacci_term_mod_decimal_assert.svh"
module ftmd_datapath import ftmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  logic [IN_W-1:0]  first_term,
	input  logic [IN_W-1:0]  second_term,
	input  logic [IN_W-1:0]  term_index,
	input  logic [DIG_W-1:0] digits,
	output dp_stat_t         stat,
	output logic [VAL_W-1:0] term_value
);

	logic [DIG_W-1:0] dig_c;
	logic [VAL_W-1:0] one_mod;

	logic [IN_W-1:0]  a_q, b_q, e_q;
	logic             n_zero_q;
	logic [VAL_W-1:0] md_q;
	logic [RCP_W-1:0] recip_q;
	logic [VAL_W-1:0] acc_x_q, acc_y_q, base_x_q, base_y_q;
	logic [VAL_W-1:0] pb1_q, pb2_q, pb3_q, pa1_q, pa2_q, pa3_q;
	logic [VAL_W-1:0] f1_q, f2_q;
	logic [VAL_W-1:0] term_value_q;

	logic [OPD_W-1:0] acc_s, base_s;
	logic [OPD_W-1:0] opa, opb;
	logic             raw_sel;
	logic [IN_W-1:0]  raw_val;
	logic             mm_valid;
	op_t              mm_op;
	logic [VAL_W-1:0] mm_res;

	assign dig_c   = (digits > DIG_W'(MAX_DIGITS)) ? DIG_W'(MAX_DIGITS) : digits;
	assign one_mod = (dig_c == '0) ? '0 : VAL_W'(1);
	assign acc_s   = {1'b0, acc_x_q} + {1'b0, acc_y_q};
	assign base_s  = {1'b0, base_x_q} + {1'b0, base_y_q};

	// Matrices are powers of Q, kept as (x, y) = (m01, m11); m00 = x + y.
	// Product of (xi, yi) and (xj, yj): y' = xi*xj + yi*yj,
	// x' = (xi+yi)*(xj+yj) - yi*yj.
	always_comb begin
		raw_sel = 1'b0;
		raw_val = a_q;
		opa     = '0;
		opb     = '0;
		case (cmd.op)
			OP_RED_A: begin
				raw_sel = 1'b1;
				raw_val = a_q;
			end
			OP_RED_B: begin
				raw_sel = 1'b1;
				raw_val = b_q;
			end
			OP_BASE_XX: begin
				opa = {1'b0, base_x_q};
				opb = {1'b0, base_x_q};
			end
			OP_BASE_YY: begin
				opa = {1'b0, base_y_q};
				opb = {1'b0, base_y_q};
			end
			OP_BASE_SS: begin
				opa = base_s;
				opb = base_s;
			end
			OP_ACC_XX: begin
				opa = {1'b0, acc_x_q};
				opb = {1'b0, base_x_q};
			end
			OP_ACC_YY: begin
				opa = {1'b0, acc_y_q};
				opb = {1'b0, base_y_q};
			end
			OP_ACC_SS: begin
				opa = acc_s;
				opb = base_s;
			end
			// answer = b*(x+y) + a*x
			OP_FIN_1: begin
				opa = {1'b0, b_q[VAL_W-1:0]};
				opb = acc_s;
			end
			OP_FIN_2: begin
				opa = {1'b0, a_q[VAL_W-1:0]};
				opb = {1'b0, acc_x_q};
			end
			default: begin
				raw_sel = 1'b0;
			end
		endcase
	end

	ftmd_mulmod u_mulmod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.issue),
		.in_op     (cmd.op),
		.raw_sel   (raw_sel),
		.raw_val   (raw_val),
		.opa       (opa),
		.opb       (opb),
		.md        (md_q),
		.recip     (recip_q),
		.out_valid (mm_valid),
		.out_op    (mm_op),
		.out_res   (mm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_zero_q <= 1'b0;
			e_q      <= '0;
		end else if (cmd.load) begin
			n_zero_q <= (term_index == '0);
			e_q      <= term_index - IN_W'(1);
		end else if (cmd.update) begin
			e_q      <= e_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q      <= first_term;
			b_q      <= second_term;
			md_q     <= MOD_TABLE[dig_c];
			recip_q  <= RECIP_TABLE[dig_c];
			acc_x_q  <= '0;
			acc_y_q  <= one_mod;
			base_x_q <= one_mod;
			base_y_q <= '0;
		end else if (cmd.update) begin
			base_y_q <= mod_add(pb1_q, pb2_q, md_q);
			base_x_q <= mod_sub(pb3_q, pb2_q, md_q);
			if (e_q[0]) begin
				acc_y_q <= mod_add(pa1_q, pa2_q, md_q);
				acc_x_q <= mod_sub(pa3_q, pa2_q, md_q);
			end
		end
		if (mm_valid) begin
			case (mm_op)
				OP_RED_A:   a_q   <= IN_W'(mm_res);
				OP_RED_B:   b_q   <= IN_W'(mm_res);
				OP_BASE_XX: pb1_q <= mm_res;
				OP_BASE_YY: pb2_q <= mm_res;
				OP_BASE_SS: pb3_q <= mm_res;
				OP_ACC_XX:  pa1_q <= mm_res;
				OP_ACC_YY:  pa2_q <= mm_res;
				OP_ACC_SS:  pa3_q <= mm_res;
				OP_FIN_1:   f1_q  <= mm_res;
				OP_FIN_2:   f2_q  <= mm_res;
				default:    f2_q  <= f2_q;
			endcase
		end
		if (cmd.finish) begin
			term_value_q <= n_zero_q ? a_q[VAL_W-1:0] : mod_add(f1_q, f2_q, md_q);
		end
	end

	assign stat.n_zero = n_zero_q;
	assign stat.e_zero = (e_q == '0);
	assign stat.e_lsb  = e_q[0];
	assign term_value  = term_value_q;

	// nothing may land in the product registers while they are being consumed
	`FTMD_ASSERT_HOLDS(a_update_drained, cmd.update, !mm_valid)
	`FTMD_ASSERT_HOLDS(a_finish_drained, cmd.finish || cmd.load, !mm_valid)
	`FTMD_ASSERT_HOLDS(a_mm_reduced, mm_valid, mm_res < md_q)
	`FTMD_ASSERT_NEXT(a_base_reduced, cmd.update, base_x_q < md_q && base_y_q < md_q)

endmodule

### sv/ftmd_ctrl.sv
// Controller state machine: sequences reduction, square-and-multiply
// rounds and the final combine. Depends on ftmd_pkg.
module ftmd_ctrl import ftmd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output logic     busy,
	output logic     done,
	output dp_cmd_t  cmd
);

	localparam logic [2:0] PAIR_LAST    = 3'd1;
	localparam logic [2:0] SQ_LAST_BASE = 3'd2;
	localparam logic [2:0] SQ_LAST_ALL  = 3'd5;
	localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(PIPE_DEPTH - 1);

	state_t               state_q, state_d;
	logic [2:0]           idx_q;
	logic [DRAIN_W-1:0]   wait_q;
	logic                 wait_done;
	logic [2:0]           sq_last;
	logic                 in_issue, in_wait;

	function automatic op_t sq_op(input logic [2:0] i);
		case (i)
			3'd0:    return OP_BASE_XX;
			3'd1:    return OP_BASE_YY;
			3'd2:    return OP_BASE_SS;
			3'd3:    return OP_ACC_XX;
			3'd4:    return OP_ACC_YY;
			3'd5:    return OP_ACC_SS;
			default: return OP_BASE_XX;
		endcase
	endfunction

	assign wait_done = (wait_q == DRAIN_LAST);
	// square the base always; multiply into the accumulator on a set bit
	assign sq_last   = stat.e_lsb ? SQ_LAST_ALL : SQ_LAST_BASE;
	assign in_issue  = (state_q == ST_RED) || (state_q == ST_SQ_ISSUE) ||
		(state_q == ST_FIN_ISSUE);
	assign in_wait   = (state_q == ST_RED_WAIT) || (state_q == ST_SQ_WAIT) ||
		(state_q == ST_FIN_WAIT);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (start) state_d = ST_RED;
			ST_RED:       if (idx_q == PAIR_LAST) state_d = ST_RED_WAIT;
			ST_RED_WAIT:  if (wait_done) state_d = ST_LOOP;
			ST_LOOP: begin
				if (stat.n_zero) begin
					state_d = ST_FINISH;
				end else if (stat.e_zero) begin
					state_d = ST_FIN_ISSUE;
				end else begin
					state_d = ST_SQ_ISSUE;
				end
			end
			ST_SQ_ISSUE:  if (idx_q == sq_last) state_d = ST_SQ_WAIT;
			ST_SQ_WAIT:   if (wait_done) state_d = ST_UPDATE;
			ST_UPDATE:    state_d = ST_LOOP;
			ST_FIN_ISSUE: if (idx_q == PAIR_LAST) state_d = ST_FIN_WAIT;
			ST_FIN_WAIT:  if (wait_done) state_d = ST_FINISH;
			ST_FINISH:    state_d = ST_DONE;
			ST_DONE:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.op     = OP_RED_A;
		case (state_q)
			ST_IDLE:      cmd.load = start;
			ST_RED: begin
				cmd.issue = 1'b1;
				cmd.op    = idx_q[0] ? OP_RED_B : OP_RED_A;
			end
			ST_SQ_ISSUE: begin
				cmd.issue = 1'b1;
				cmd.op    = sq_op(idx_q);
			end
			ST_FIN_ISSUE: begin
				cmd.issue = 1'b1;
				cmd.op    = idx_q[0] ? OP_FIN_2 : OP_FIN_1;
			end
			ST_UPDATE:    cmd.update = 1'b1;
			ST_FINISH:    cmd.finish = 1'b1;
			default:      cmd.load   = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			wait_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= (in_issue && state_d == state_q) ? idx_q + 3'd1 : '0;
			wait_q  <= (in_wait && state_d == state_q) ? wait_q + DRAIN_W'(1) : '0;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

### sv/fibonacci_term_mod_decimal.sv
// Index 0 skips the exponent walk and the final combine; any other index walks
// the exponent (index-1) up to its highest set bit.
// Throughput: one item at a time; start is taken again the cycle after done.
// The rate is set by one shared four-stage mulmod unit: 3 or 6 products per exponent bit.
// Reset (arst_n low, asynchronous) returns the controller to idle and empties the unit.
// The result beat is shown for one cycle on done; the receiver cannot stall it.
module fibonacci_term_mod_decimal import ftmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [IN_W-1:0]  first_term,
	input  logic [IN_W-1:0]  second_term,
	input  logic [IN_W-1:0]  term_index,
	input  logic [DIG_W-1:0] digits,
	output logic             done,
	output logic [VAL_W-1:0] term_value
);

	// Flow: reduce both start terms mod 10^d, then walk the exponent (index-1)
	// from its low bit, squaring the base matrix each round and folding it into
	// the accumulator on a set bit, then combine b*(x+y) + a*x; index 0 gives a.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	ftmd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// The datapath holds the item, the matrix state and the result register.
	ftmd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.first_term  (first_term),
		.second_term (second_term),
		.term_index  (term_index),
		.digits      (digits),
		.stat        (stat),
		.term_value  (term_value)
	);

endmodule

### tb/fibonacci_term_mod_decimal_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for fibonacci_term_mod_decimal: directed rows, then random beats.
// Depends on ftmd_pkg for port widths and MAX_DIGITS; needs nothing beyond the RTL.
module fibonacci_term_mod_decimal_tb;
	import ftmd_pkg::*;

	localparam int RANDOM_ITEMS  = 530;
	localparam int CALM_TAIL     = 60;    // last random beats go in back to back
	localparam int STALL_LIMIT   = 4000;  // watchdog limit on edges with no beat
	localparam int SETTLE_CYCLES = 400;   // listen for stray results at the end
	localparam int REPORT_MAX    = 10;
	localparam int NUM_ROWS      = 20;

	localparam logic [IN_W-1:0] TERM_MAX = {IN_W{1'b1}};

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [IN_W-1:0]  first_term;
	logic [IN_W-1:0]  second_term;
	logic [IN_W-1:0]  term_index;
	logic [DIG_W-1:0] digits;
	logic             done;
	logic [VAL_W-1:0] term_value;

	// Residues the block still owes, oldest first.
	logic [VAL_W-1:0] pending_terms [$];

	int mismatches    = 0;
	int beats_sent    = 0;
	int results_seen  = 0;
	int clamped_sent  = 0;
	int wide_idx_sent = 0;
	int gap_pct       = 0;
	int stall_cycles  = 0;

	fibonacci_term_mod_decimal dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.first_term (first_term),
		.second_term(second_term),
		.term_index (term_index),
		.digits     (digits),
		.done       (done),
		.term_value (term_value)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: f(n) mod 10^d by 2x2 matrix power, clamped digit count.
	// ------------------------------------------------------------------
	typedef struct {
		longint unsigned m00, m01, m10, m11;
	} fib_mat_t;

	function automatic fib_mat_t fib_mat_mul(input fib_mat_t x, input fib_mat_t y,
		input longint unsigned md);
		fib_mat_t r;
		r.m00 = (x.m00 * y.m00 + x.m01 * y.m10) % md;
		r.m01 = (x.m00 * y.m01 + x.m01 * y.m11) % md;
		r.m10 = (x.m10 * y.m00 + x.m11 * y.m10) % md;
		r.m11 = (x.m10 * y.m01 + x.m11 * y.m11) % md;
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] fib_residue(input logic [IN_W-1:0] f0,
		input logic [IN_W-1:0] f1, input logic [IN_W-1:0] idx,
		input logic [DIG_W-1:0] dig);
		longint unsigned md, a, b, e, r;
		int unsigned     nd;
		fib_mat_t        acc, base;
		nd = (dig > MAX_DIGITS) ? MAX_DIGITS : dig;
		md = 1;
		repeat (nd) md = md * 10;
		a = f0 % md;
		b = f1 % md;
		if (idx == 0) begin
			r = a;
		end else if (idx == 1) begin
			r = b;
		end else if (idx == 2) begin
			r = (a + b) % md;
		end else begin
			// Q^(n-1), with the identity and Q themselves reduced (mod 1 gives zeros)
			acc  = '{1 % md, 0, 0, 1 % md};
			base = '{1 % md, 1 % md, 1 % md, 0};
			e = 64'(idx) - 64'd1;
			while (e != 0) begin
				if (e[0]) begin
					acc = fib_mat_mul(acc, base, md);
				end
				base = fib_mat_mul(base, base, md);
				e = e >> 1;
			end
			r = (b * acc.m00 + a * acc.m01) % md;
		end
		return r[VAL_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Directed rows. Where fixed is set, the residue is typed in by hand;
	// otherwise the predictor supplies it.
	// ------------------------------------------------------------------
	typedef struct {
		logic [IN_W-1:0]  a;
		logic [IN_W-1:0]  b;
		logic [IN_W-1:0]  n;
		logic [DIG_W-1:0] d;
		bit               fixed;
		logic [VAL_W-1:0] value;
	} term_row_t;

	term_row_t directed_rows [NUM_ROWS] = '{
		// all zero, index zero, one digit
		'{31'd0,       31'd0,       31'd0,        3'd1, 1'b1, 14'd0},
		// index zero hands back the first term, reduced
		'{31'd1234567, 31'd5,       31'd0,        3'd4, 1'b1, 14'd4567},
		// index one hands back the second term, reduced
		'{31'd8,       31'd7654321, 31'd1,        3'd3, 1'b1, 14'd321},
		// index two wraps the sum exactly to zero
		'{31'd9999,    31'd1,       31'd2,        3'd4, 1'b1, 14'd0},
		// first matrix case, start terms reduced first
		'{31'd5,       31'd7,       31'd3,        3'd1, 1'b1, 14'd9},
		'{31'd0,       31'd1,       31'd3,        3'd4, 1'b1, 14'd2},
		'{31'd0,       31'd1,       31'd10,       3'd4, 1'b1, 14'd55},
		'{31'd0,       31'd1,       31'd20,       3'd4, 1'b0, 14'd0},
		'{31'd0,       31'd1,       31'd30,       3'd2, 1'b0, 14'd0},
		// one full period of the last decimal digit
		'{31'd0,       31'd1,       31'd60,       3'd1, 1'b0, 14'd0},
		// largest start terms at the small indexes
		'{TERM_MAX,    TERM_MAX,    31'd0,        3'd4, 1'b1, 14'd3647},
		'{TERM_MAX,    TERM_MAX,    31'd1,        3'd1, 1'b1, 14'd7},
		// zero digits: modulus one, every answer zero
		'{TERM_MAX,    TERM_MAX,    TERM_MAX,     3'd0, 1'b1, 14'd0},
		'{31'd3,       31'd4,       31'd1,        3'd0, 1'b1, 14'd0},
		// digit counts above four clamp to four
		'{TERM_MAX,    31'd123456,  31'd1,        3'd7, 1'b1, 14'd3456},
		'{31'd11,      31'd13,      31'd1000,     3'd5, 1'b0, 14'd0},
		'{31'd17,      31'd19,      31'd77777,    3'd6, 1'b0, 14'd0},
		// longest exponent, index with a single high bit, index with alternating bits
		'{TERM_MAX,    TERM_MAX,    TERM_MAX,     3'd4, 1'b0, 14'd0},
		'{31'd2,       31'd1,       31'h40000000, 3'd4, 1'b0, 14'd0},
		'{31'h2AAAAAAA, 31'h55555555, 31'h55555555, 3'd3, 1'b0, 14'd0}
	};

	// ------------------------------------------------------------------
	// Send one beat: optionally idle a burst, then hold start with the
	// fields until the block takes them, and log the residue it owes.
	// ------------------------------------------------------------------
	task automatic send_term(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b,
		input logic [IN_W-1:0] n, input logic [DIG_W-1:0] d,
		input logic [VAL_W-1:0] want);
		int gap;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			gap = $urandom_range(1, 8);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		first_term  <= a;
		second_term <= b;
		term_index  <= n;
		digits      <= d;
		// advance until an edge sees start high with busy low
		do @(posedge clk); while (!(start && !busy));
		pending_terms.push_back(want);
		beats_sent++;
		if (d == 0 || d > MAX_DIGITS) clamped_sent++;
		if (n >= 31'd65536) wide_idx_sent++;
	endtask

	// ------------------------------------------------------------------
	// Result check: done is a one-cycle strobe; match it to the oldest
	// expectation. Values are sampled before the edge updates them.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic [VAL_W-1:0] want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_terms.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: result %0d with nothing owed", $realtime, term_value);
			end else begin
				want = pending_terms.pop_front();
				if (term_value !== want) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: term_value expected %0d, got %0d (result %0d)",
							$realtime, want, term_value, results_seen);
				end
			end
		end
	end

	// Watchdog: count edges at which neither side moves a beat.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results still owed",
				STALL_LIMIT, pending_terms.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run.
	// ------------------------------------------------------------------
	initial begin
		logic [IN_W-1:0]  a, b, n;
		logic [DIG_W-1:0] d;
		logic [VAL_W-1:0] want;

		// hold every input at a known value through reset
		arst_n      <= 1'b0;
		start       <= 1'b0;
		first_term  <= '0;
		second_term <= '0;
		term_index  <= '0;
		digits      <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 25;
		foreach (directed_rows[i]) begin
			want = directed_rows[i].fixed ? directed_rows[i].value :
				fib_residue(directed_rows[i].a, directed_rows[i].b,
					directed_rows[i].n, directed_rows[i].d);
			send_term(directed_rows[i].a, directed_rows[i].b, directed_rows[i].n,
				directed_rows[i].d, want);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// change the idle density every 40 beats; none in the tail
			if (i % 40 == 0) begin
				case ($urandom_range(2))
					0: gap_pct = 0;
					1: gap_pct = 25;
					default: gap_pct = 60;
				endcase
			end
			if (i >= RANDOM_ITEMS - CALM_TAIL) gap_pct = 0;

			a = ($urandom_range(9) < 7) ? IN_W'($urandom) : IN_W'($urandom_range(20000));
			b = ($urandom_range(9) < 7) ? IN_W'($urandom) : IN_W'($urandom_range(20000));
			case ($urandom_range(9))
				0:       n = IN_W'($urandom_range(3));
				1, 2, 3: n = IN_W'($urandom_range(255));
				4:       n = TERM_MAX - IN_W'($urandom_range(15));
				default: n = IN_W'($urandom);
			endcase
			d = ($urandom_range(9) < 8) ? DIG_W'($urandom_range(1, MAX_DIGITS)) :
				DIG_W'($urandom_range(7));
			send_term(a, b, n, d, fib_residue(a, b, n, d));
		end

		// drop start at the edge that took the last beat
		start <= 1'b0;
		while (pending_terms.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d beats (%0d directed), checked %0d results", beats_sent,
			NUM_ROWS, results_seen);
		$display("digit counts outside 1..4: %0d, indexes of 2^16 and up: %0d, mismatches: %0d",
			clamped_sent, wide_idx_sent, mismatches);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
